// ===== rtl/core/buddy_block_allocator_macros.svh =====
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shorthand for clocked concurrent assertions, with or without a reset gate.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_MACROS_SVH

// Concurrent check on a clock, disabled while reset is asserted (active low).
`define BBA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same check without a reset gate.
`define BBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/bba_pkg.sv =====
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants of the buddy block allocator.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int PoolUnitsDef = 1024;
    localparam int OpW          = 1;
    localparam int ReqW         = 11;
    localparam int OffW         = 10;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic STS_OK   = 1'b0;
    localparam logic STS_FAIL = 1'b1;

    typedef enum logic [1:0] {
        ND_ABSENT = 2'd0,
        ND_FREE   = 2'd1,
        ND_USED   = 2'd2,
        ND_SPLIT  = 2'd3
    } t_node;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE,
        S_A_RD, S_A_EV, S_A_WL, S_A_WR, S_A_DN, S_A_BK,
        S_F_RD, S_F_EV, S_F_UP,
        S_M_RDL, S_M_RDR, S_M_CHK, S_M_WL, S_M_WR, S_M_WP,
        S_FIN_FAIL, S_FIN_AOK, S_FIN_FOK
    } t_state;

    typedef enum logic [4:0] {
        CMD_NONE, CMD_CLR, CMD_LOAD, CMD_READ, CMD_READ_L, CMD_READ_R,
        CMD_DOWN_L, CMD_DOWN_T, CMD_BACK, CMD_UP,
        CMD_WR_SPLIT, CMD_WR_USED, CMD_WR_FREE,
        CMD_WR_CL_FREE, CMD_WR_CR_FREE, CMD_WR_CL_ABS, CMD_WR_CR_ABS,
        CMD_FIN_FAIL, CMD_FIN_AOK, CMD_FIN_FOK
    } t_cmd;

    typedef struct packed {
        logic  clear_last;
        t_node st;
        logic  child_ok;
        logic  fits;
        logic  can_split;
        logic  off_match;
        logic  is_left;
        logic  at_root;
        logic  idx_zero;
        logic  both_free;
        logic  res_room;
    } t_dp_sts;

endpackage

// ===== rtl/core/bba_if.sv =====
// ----------------------------------------------------------------------------
// bba_req_if / bba_res_if
// Valid/ready channels for request words and result words.
// ----------------------------------------------------------------------------
interface bba_req_if;
    import bba_pkg::*;
    logic                valid;
    logic                ready;
    logic [OpW-1:0]      op;
    logic [ReqW-1:0]     request_size;
    logic [OffW-1:0]     block_offset;

    modport source (output valid, op, request_size, block_offset, input ready);
    modport sink   (input valid, op, request_size, block_offset, output ready);
endinterface

interface bba_res_if;
    import bba_pkg::*;
    logic                valid;
    logic                ready;
    logic                status;
    logic [OffW-1:0]     given_offset;

    modport source (output valid, status, given_offset, input ready);
    modport sink   (input valid, status, given_offset, output ready);
endinterface

// ===== rtl/core/buddy_block_allocator.sv =====
// ----------------------------------------------------------------------------
// buddy_block_allocator
// Buddy allocator over a pool of PoolUnits units, one request word at a time.
// ----------------------------------------------------------------------------
// The pool is held as a heap-ordered tree of 2*PoolUnits two-bit node states
// (absent, free leaf, allocated leaf, split) in a store with one read and one
// write port. After reset a clearing pass writes every node, one per cycle,
// during which no request is taken. An allocate word finds the lowest-addressed
// free leaf at least the requested size (0 counts as 1), halving it leftward
// while it exceeds twice the request; it returns the leaf offset or a fail
// status. A free word releases the allocated leaf starting at block_offset and
// merges free buddies upward. An allocate reads and evaluates each node it
// visits, writes both children free on each split and steps to a sibling or
// parent on each backtrack; a free reads each level down, and each merge reads
// both children, writes them absent and writes the parent free, until a buddy
// is not free or the walk passes the root. Each request is loaded before its
// walk and its result is registered at finish. A deeply fragmented search can
// visit many nodes. One request is in flight at a time; the result register
// lets the next request start while a result waits.
// ----------------------------------------------------------------------------
module buddy_block_allocator
    import bba_pkg::*;
#(
    parameter int PoolUnits = PoolUnitsDef
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    bba_req_if.sink   i_req,
    bba_res_if.source o_res
);

    t_cmd    cmd;
    t_dp_sts sts;

    bba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_op    (i_req.op),
        .i_sts      (sts),
        .o_in_ready (i_req.ready),
        .o_cmd      (cmd)
    );

    bba_dp #(
        .PoolUnits (PoolUnits)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_req_size   (i_req.request_size),
        .i_target     (i_req.block_offset),
        .i_res_ready  (o_res.ready),
        .o_sts        (sts),
        .o_res_valid  (o_res.valid),
        .o_res_status (o_res.status),
        .o_res_offset (o_res.given_offset)
    );

endmodule

// ===== rtl/core/bba_ctrl.sv =====
// ----------------------------------------------------------------------------
// bba_ctrl
// Sequencer: issues datapath commands, one tree step per cycle; it holds at finish while an unread result waits.
// ----------------------------------------------------------------------------
module bba_ctrl
    import bba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_in_op,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_in_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (i_sts.clear_last) n_state = S_IDLE;
            S_IDLE: begin
                if (accept) n_state = (i_in_op == OP_FREE) ? S_F_RD : S_A_RD;
            end
            S_A_RD: n_state = S_A_EV;
            S_A_EV: begin
                if (i_sts.st == ND_SPLIT) begin
                    n_state = i_sts.child_ok ? S_A_RD : S_A_BK;
                end else if (i_sts.st == ND_FREE && i_sts.fits) begin
                    n_state = (i_sts.can_split && i_sts.child_ok) ? S_A_WL : S_FIN_AOK;
                end else begin
                    n_state = S_A_BK;
                end
            end
            S_A_WL: n_state = S_A_WR;
            S_A_WR: n_state = S_A_DN;
            S_A_DN: n_state = S_A_RD;
            S_A_BK: begin
                if (i_sts.at_root)      n_state = S_FIN_FAIL;
                else if (i_sts.is_left) n_state = S_A_RD;
            end
            S_F_RD: n_state = S_F_EV;
            S_F_EV: begin
                if (i_sts.st == ND_SPLIT && i_sts.child_ok)       n_state = S_F_RD;
                else if (i_sts.st == ND_USED && i_sts.off_match)  n_state = S_F_UP;
                else                                              n_state = S_FIN_FAIL;
            end
            S_F_UP:  n_state = S_M_RDL;
            S_M_RDL: n_state = i_sts.idx_zero ? S_FIN_FOK : S_M_RDR;
            S_M_RDR: n_state = S_M_CHK;
            S_M_CHK: n_state = i_sts.both_free ? S_M_WL : S_FIN_FOK;
            S_M_WL:  n_state = S_M_WR;
            S_M_WR:  n_state = S_M_WP;
            S_M_WP:  n_state = S_F_UP;
            S_FIN_FAIL, S_FIN_AOK, S_FIN_FOK: begin
                if (i_sts.res_room) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_comb begin
        o_cmd      = CMD_NONE;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLEAR: o_cmd = CMD_CLR;
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (accept) o_cmd = CMD_LOAD;
            end
            S_A_RD, S_F_RD: o_cmd = CMD_READ;
            S_A_EV: begin
                if (i_sts.st == ND_SPLIT) begin
                    if (i_sts.child_ok) o_cmd = CMD_DOWN_L;
                end else if (i_sts.st == ND_FREE && i_sts.fits) begin
                    o_cmd = (i_sts.can_split && i_sts.child_ok) ? CMD_WR_SPLIT : CMD_WR_USED;
                end
            end
            S_A_WL: o_cmd = CMD_WR_CL_FREE;
            S_A_WR: o_cmd = CMD_WR_CR_FREE;
            S_A_DN: o_cmd = CMD_DOWN_L;
            S_A_BK: if (!i_sts.at_root) o_cmd = CMD_BACK;
            S_F_EV: begin
                if (i_sts.st == ND_SPLIT && i_sts.child_ok)      o_cmd = CMD_DOWN_T;
                else if (i_sts.st == ND_USED && i_sts.off_match) o_cmd = CMD_WR_FREE;
            end
            S_F_UP:  o_cmd = CMD_UP;
            S_M_RDL: if (!i_sts.idx_zero) o_cmd = CMD_READ_L;
            S_M_RDR: o_cmd = CMD_READ_R;
            S_M_CHK: o_cmd = CMD_NONE;
            S_M_WL:  o_cmd = CMD_WR_CL_ABS;
            S_M_WR:  o_cmd = CMD_WR_CR_ABS;
            S_M_WP:  o_cmd = CMD_WR_FREE;
            S_FIN_FAIL: if (i_sts.res_room) o_cmd = CMD_FIN_FAIL;
            S_FIN_AOK:  if (i_sts.res_room) o_cmd = CMD_FIN_AOK;
            S_FIN_FOK:  if (i_sts.res_room) o_cmd = CMD_FIN_FOK;
            default: o_cmd = CMD_NONE;
        endcase
    end

endmodule

// ===== rtl/core/bba_dp.sv =====
// ----------------------------------------------------------------------------
// bba_dp
// Node store, tree cursor (index, depth, offset) and result register.
// ----------------------------------------------------------------------------
module bba_dp
    import bba_pkg::*;
#(
    parameter int PoolUnits = PoolUnitsDef
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [ReqW-1:0]   i_req_size,
    input  logic [OffW-1:0]   i_target,
    input  logic              i_res_ready,
    output t_dp_sts           o_sts,
    output logic              o_res_valid,
    output logic              o_res_status,
    output logic [OffW-1:0]   o_res_offset
);

    localparam int NodeCount = 2 * PoolUnits;
    localparam int IW        = $clog2(NodeCount);
    localparam int OW        = $clog2(PoolUnits);
    localparam int SW        = $clog2(PoolUnits + 1);
    localparam int AW        = ((SW > ReqW) ? SW : ReqW) + 2;
    localparam int DW        = $clog2(IW);

    t_node            r_mem [NodeCount];
    t_node            r_rd_data;
    t_node            r_left_st;
    logic [IW-1:0]    r_clr;
    logic [IW-1:0]    r_idx;
    logic [DW-1:0]    r_depth;
    logic [OW-1:0]    r_off;
    logic [ReqW-1:0]  r_req;
    logic [OffW-1:0]  r_target;
    logic             r_res_valid;
    logic             r_res_status;
    logic [OffW-1:0]  r_res_offset;

    logic [IW-1:0]    rd_addr;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    t_node            wr_data;
    logic [IW-1:0]    idx_l;
    logic [IW-1:0]    idx_r;
    logic [IW:0]      idx_r_wide;
    logic [AW-1:0]    size_cur;
    logic [AW-1:0]    half;
    logic [AW-1:0]    req_eff;
    logic [AW-1:0]    off_wide;
    logic [AW-1:0]    mid;
    logic             res_room;

    assign idx_l      = {r_idx[IW-2:0], 1'b0};
    assign idx_r      = {r_idx[IW-2:0], 1'b1};
    assign idx_r_wide = {r_idx, 1'b1};
    assign size_cur   = AW'(PoolUnits) >> r_depth;
    assign half       = size_cur >> 1;
    assign req_eff    = (r_req == '0) ? AW'(1) : AW'(r_req);
    assign off_wide   = AW'(r_off);
    assign mid        = off_wide + half;
    assign res_room   = !r_res_valid || i_res_ready;

    always_comb begin
        o_sts.clear_last = (r_clr == IW'(NodeCount - 1));
        o_sts.st         = r_rd_data;
        o_sts.child_ok   = (idx_r_wide < (IW + 1)'(NodeCount));
        o_sts.fits       = (size_cur >= req_eff);
        o_sts.can_split  = (size_cur > (req_eff << 1));
        o_sts.off_match  = (off_wide == AW'(r_target));
        o_sts.is_left    = !r_idx[0];
        o_sts.at_root    = (r_idx == IW'(1));
        o_sts.idx_zero   = (r_idx == '0);
        o_sts.both_free  = (r_left_st == ND_FREE) && (r_rd_data == ND_FREE);
        o_sts.res_room   = res_room;
    end

    // Store port selection.
    always_comb begin
        rd_addr = r_idx;
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = ND_ABSENT;
        case (i_cmd)
            CMD_READ_L: rd_addr = idx_l;
            CMD_READ_R: rd_addr = idx_r;
            CMD_CLR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr;
                wr_data = (r_clr == IW'(1)) ? ND_FREE : ND_ABSENT;
            end
            CMD_WR_SPLIT: begin
                wr_en = 1'b1; wr_data = ND_SPLIT;
            end
            CMD_WR_USED: begin
                wr_en = 1'b1; wr_data = ND_USED;
            end
            CMD_WR_FREE: begin
                wr_en = 1'b1; wr_data = ND_FREE;
            end
            CMD_WR_CL_FREE: begin
                wr_en = 1'b1; wr_addr = idx_l; wr_data = ND_FREE;
            end
            CMD_WR_CR_FREE: begin
                wr_en = 1'b1; wr_addr = idx_r; wr_data = ND_FREE;
            end
            CMD_WR_CL_ABS: begin
                wr_en = 1'b1; wr_addr = idx_l; wr_data = ND_ABSENT;
            end
            CMD_WR_CR_ABS: begin
                wr_en = 1'b1; wr_addr = idx_r; wr_data = ND_ABSENT;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Tree cursor.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd == CMD_CLR) begin
            r_clr <= r_clr + IW'(1);
        end
        case (i_cmd)
            CMD_LOAD: begin
                r_idx    <= IW'(1);
                r_depth  <= '0;
                r_off    <= '0;
                r_req    <= i_req_size;
                r_target <= i_target;
            end
            CMD_READ_R: r_left_st <= r_rd_data;
            CMD_DOWN_L: begin
                r_idx   <= idx_l;
                r_depth <= r_depth + DW'(1);
            end
            CMD_DOWN_T: begin
                r_depth <= r_depth + DW'(1);
                if (AW'(r_target) < mid) begin
                    r_idx <= idx_l;
                end else begin
                    r_idx <= idx_r;
                    r_off <= OW'(mid);
                end
            end
            CMD_BACK: begin
                if (!r_idx[0]) begin
                    // left subtree failed: try its right sibling
                    r_idx <= r_idx + IW'(1);
                    r_off <= OW'(off_wide + size_cur);
                end else begin
                    r_idx   <= r_idx >> 1;
                    r_depth <= r_depth - DW'(1);
                    r_off   <= OW'(off_wide - size_cur);
                end
            end
            CMD_UP: r_idx <= r_idx >> 1;
            default: ;
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (i_cmd == CMD_FIN_FAIL || i_cmd == CMD_FIN_AOK ||
                     i_cmd == CMD_FIN_FOK) begin
            r_res_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_res_valid <= 1'b0;
        end
        case (i_cmd)
            CMD_FIN_FAIL: begin
                r_res_status <= STS_FAIL;
                r_res_offset <= '0;
            end
            CMD_FIN_AOK: begin
                r_res_status <= STS_OK;
                r_res_offset <= off_wide[OffW-1:0];
            end
            CMD_FIN_FOK: begin
                r_res_status <= STS_OK;
                r_res_offset <= '0;
            end
            default: ;
        endcase
    end

    assign o_res_valid  = r_res_valid;
    assign o_res_status = r_res_status;
    assign o_res_offset = r_res_offset;

endmodule

// ===== rtl/core/bba_checker.sv =====
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "buddy_block_allocator_macros.svh"

module bba_checker
    import bba_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_req_valid,
    input logic            i_req_ready,
    input logic            i_res_valid,
    input logic            i_res_ready,
    input logic            i_res_status,
    input logic [OffW-1:0] i_res_offset
);

    // one request in flight: ready drops right after a word is taken
    `BBA_ASSERT(a_one_in_flight, i_clk, i_rst_n, (i_req_valid && i_req_ready) |=> !i_req_ready, "ready stayed high after accept")
    // failed results, from allocate or free, carry a zero offset
    `BBA_ASSERT(a_fail_zero, i_clk, i_rst_n, (i_res_valid && (i_res_status == STS_FAIL)) |-> (i_res_offset == '0), "fail result with nonzero offset")
    // a result word is raised only by a busy cycle, never from idle
    `BBA_ASSERT(a_no_early_res, i_clk, i_rst_n, $rose(i_res_valid) |-> $past(!i_req_ready), "result rose while idle")
    `BBA_ASSERT(a_res_hold, i_clk, i_rst_n, (i_res_valid && !i_res_ready) |=> (i_res_valid && $stable(i_res_status) && $stable(i_res_offset)), "stalled result changed")

endmodule

bind buddy_block_allocator bba_checker u_bba_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_status (o_res.status),
    .i_res_offset (o_res.given_offset)
);
